>>> sv/b4rs_pkg.sv
// Package for the base-4 key radix sorter.
// Holds the key and bus widths and the control structs shared by the sequencer and the top level.
// No dependencies.
`default_nettype none

package b4rs_pkg;

  // Key width: ten base-4 digits, two bits per digit.
  localparam int KEY_W  = 20;
  // Stream data width: key padded up to whole bytes.
  localparam int DATA_W = 24;

  typedef logic [KEY_W-1:0] key_t;

  // Enables for one key RAM.
  typedef struct packed {
    logic wen;
    logic ren;
  } ram_ctl_t;

  // Output stage status handed from the sequencer to the top level.
  typedef struct packed {
    logic valid;     // the RAM read register holds a key to send
    logic last;      // that key is the final one of the run
    logic ovf;       // keys of this run were dropped
    logic sel;       // RAM that holds the sorted run (0: A, 1: B)
  } out_ctl_t;

endpackage

`default_nettype wire

>>> sv/base4_key_radix_sorter_core.sv
// Channel  | signals                       | transaction
// ---------+-------------------------------+-------------------------------------
// s_       | tvalid tready tdata tlast     | one key; tlast closes the set
// m_       | tvalid tready tdata tlast tuser| one sorted key; tlast on the final one
//
// Loading takes one key per cycle into key RAM A. After the key marked last the block
// sorts in DIGITS passes over the n stored keys: each pass scans the source RAM
// once per digit value through its single read port, writing matches to the other RAM.
// The sorted run then leaves at one key per cycle while the sink is ready; s_tready is
// low from the last key until the final sorted key is taken. Reset clears the control
// state only; there is no clearing pass. A stalled sink holds the run without loss.
// Top level of the base-4 key radix sorter; depends on b4rs_pkg, b4rs_key_ram and
// b4rs_sequencer.
`default_nettype none

module base4_key_radix_sorter_core #(
  parameter int MAX_KEYS = 64,
  parameter int DIGITS   = 10
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire  [b4rs_pkg::DATA_W-1:0]  s_tdata,   // [19:0] key, [23:20] zero
  input  wire                          s_tlast,   // last
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [b4rs_pkg::DATA_W-1:0]  m_tdata,   // [19:0] sorted_key, [23:20] zero
  output logic                         m_tlast,   // end_of_run
  output logic                         m_tuser    // [0] overflow
);
  import b4rs_pkg::*;

  localparam int AW = $clog2(MAX_KEYS);

  ram_ctl_t      a_ctl;
  ram_ctl_t      b_ctl;
  out_ctl_t      out_ctl;
  logic [AW-1:0] a_waddr;
  logic [AW-1:0] b_waddr;
  logic [AW-1:0] raddr;
  key_t          wdata;
  key_t          a_rdata;
  key_t          b_rdata;
  key_t          out_key;

  // Control and digit scan.
  b4rs_sequencer #(
    .MAX_KEYS (MAX_KEYS),
    .DIGITS   (DIGITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_key    (s_tdata[KEY_W-1:0]),
    .in_last   (s_tlast),
    .out_ready (m_tready),
    .out_ctl   (out_ctl),
    .a_ctl     (a_ctl),
    .b_ctl     (b_ctl),
    .a_waddr   (a_waddr),
    .b_waddr   (b_waddr),
    .raddr     (raddr),
    .wdata     (wdata),
    .a_rdata   (a_rdata),
    .b_rdata   (b_rdata)
  );

  // Ping-pong key stores.
  b4rs_key_ram #(
    .DEPTH (MAX_KEYS)
  ) u_ram_a (
    .clk   (clk),
    .wen   (a_ctl.wen),
    .waddr (a_waddr),
    .wdata (wdata),
    .ren   (a_ctl.ren),
    .raddr (raddr),
    .rdata (a_rdata)
  );

  b4rs_key_ram #(
    .DEPTH (MAX_KEYS)
  ) u_ram_b (
    .clk   (clk),
    .wen   (b_ctl.wen),
    .waddr (b_waddr),
    .wdata (wdata),
    .ren   (b_ctl.ren),
    .raddr (raddr),
    .rdata (b_rdata)
  );

  // The read register of the RAM holding the sorted run is the output register.
  assign out_key  = out_ctl.sel ? b_rdata : a_rdata;
  assign m_tvalid = out_ctl.valid;
  assign m_tdata  = {{(DATA_W - KEY_W){1'b0}}, out_key};
  assign m_tlast  = out_ctl.last;
  assign m_tuser  = out_ctl.ovf;

endmodule

`default_nettype wire

>>> sv/b4rs_key_ram.sv
// Single-port-write, single-port-read key RAM with a registered read.
// The read register only updates when a read is enabled, so it also holds a stalled output.
// Depends on b4rs_pkg.
`default_nettype none

module b4rs_key_ram #(
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire                   clk,
  input  wire                   wen,
  input  wire  [AW-1:0]         waddr,
  input  wire  b4rs_pkg::key_t  wdata,
  input  wire                   ren,
  input  wire  [AW-1:0]         raddr,
  output b4rs_pkg::key_t        rdata
);
  import b4rs_pkg::*;

  key_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered, holds its data while not enabled.
  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/b4rs_sequencer.sv
// Sequencer for the base-4 key radix sorter: loads keys into RAM A, runs one stable
// scanning pass per digit between RAMs A and B, then streams the sorted run out.
// Depends on b4rs_pkg; drives two b4rs_key_ram instances held by the top level.
`default_nettype none

module b4rs_sequencer #(
  parameter int MAX_KEYS = 64,
  parameter int DIGITS   = 10,
  localparam int AW      = $clog2(MAX_KEYS)
) (
  input  wire                    clk,
  input  wire                    rst,
  // Key input.
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire  b4rs_pkg::key_t   in_key,
  input  wire                    in_last,
  // Output stage.
  input  wire                    out_ready,
  output b4rs_pkg::out_ctl_t     out_ctl,
  // RAM ports.
  output b4rs_pkg::ram_ctl_t     a_ctl,
  output b4rs_pkg::ram_ctl_t     b_ctl,
  output logic [AW-1:0]          a_waddr,
  output logic [AW-1:0]          b_waddr,
  output logic [AW-1:0]          raddr,
  output b4rs_pkg::key_t         wdata,
  input  wire  b4rs_pkg::key_t   a_rdata,
  input  wire  b4rs_pkg::key_t   b_rdata
);
  import b4rs_pkg::*;

  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int DW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_SORT = 2'd1;
  localparam logic [1:0] ST_TAIL = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]    state;
  logic [CW-1:0] count;
  logic          dropped;
  logic          src;
  logic [DW-1:0] dig;
  logic [1:0]    val;
  logic [CW-1:0] idx;
  logic [CW-1:0] pos;
  logic [CW-1:0] pos_next;
  logic          rd_pend;
  logic [1:0]    rd_val;
  logic [CW-1:0] oidx;
  logic          out_valid;
  logic          out_last;

  logic          accept;
  logic          has_room;
  logic [CW-1:0] count_m1;
  key_t          src_rdata;
  key_t          shifted;
  logic [DW:0]   shamt;
  logic          sort_wen;
  logic          emit_ren;
  logic          sort_ren;
  logic          load_wen;

  // Handshake and occupancy.
  assign in_ready = (state == ST_LOAD);
  assign accept   = in_valid && in_ready;
  assign has_room = (count < CW'(MAX_KEYS));
  assign count_m1 = count - CW'(1);

  // Digit of the key returned by the source RAM; digits above the key read as zero.
  assign src_rdata = src ? b_rdata : a_rdata;
  assign shamt     = {dig, 1'b0};
  assign shifted   = src_rdata >> shamt;
  assign sort_wen  = rd_pend && (shifted[1:0] == rd_val);
  assign pos_next  = pos + CW'(sort_wen);

  // RAM control: load writes A, a pass reads the source and writes the other RAM.
  assign load_wen = accept && has_room;
  assign sort_ren = (state == ST_SORT);
  assign emit_ren = (state == ST_EMIT) && (oidx != count) && (!out_valid || out_ready);

  assign a_ctl.wen = load_wen || (sort_wen && src);
  assign a_ctl.ren = (sort_ren || emit_ren) && !src;
  assign b_ctl.wen = sort_wen && !src;
  assign b_ctl.ren = (sort_ren || emit_ren) && src;
  assign a_waddr   = (state == ST_LOAD) ? count[AW-1:0] : pos[AW-1:0];
  assign b_waddr   = pos[AW-1:0];
  assign raddr     = (state == ST_EMIT) ? oidx[AW-1:0] : idx[AW-1:0];
  assign wdata     = (state == ST_LOAD) ? in_key : src_rdata;

  assign out_ctl.valid = out_valid;
  assign out_ctl.last  = out_last;
  assign out_ctl.ovf   = dropped;
  assign out_ctl.sel   = src;

  // Main sequence: load, DIGITS scan passes, emission.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      dropped   <= 1'b0;
      src       <= 1'b0;
      dig       <= '0;
      val       <= '0;
      idx       <= '0;
      pos       <= '0;
      rd_pend   <= 1'b0;
      rd_val    <= '0;
      oidx      <= '0;
      out_valid <= 1'b0;
      out_last  <= 1'b0;
    end else begin
      rd_pend <= (state == ST_SORT);
      rd_val  <= val;
      pos     <= pos_next;
      unique case (state)
        ST_LOAD: begin
          if (accept) begin
            if (has_room) begin
              count <= count + CW'(1);
            end else begin
              dropped <= 1'b1;
            end
            if (in_last) begin
              state <= ST_SORT;
              src   <= 1'b0;
              dig   <= '0;
              val   <= '0;
              idx   <= '0;
              pos   <= '0;
            end
          end
        end
        ST_SORT: begin
          // Scan every stored key once for each digit value, in order.
          if (idx == count_m1) begin
            idx <= '0;
            if (val == 2'd3) begin
              state <= ST_TAIL;
            end else begin
              val <= val + 2'd1;
            end
          end else begin
            idx <= idx + CW'(1);
          end
        end
        ST_TAIL: begin
          // The last read of the pass lands here; then swap source and destination.
          src <= !src;
          val <= '0;
          idx <= '0;
          pos <= '0;
          if (dig == DW'(DIGITS - 1)) begin
            state     <= ST_EMIT;
            oidx      <= '0;
            out_valid <= 1'b0;
          end else begin
            state <= ST_SORT;
            dig   <= dig + DW'(1);
          end
        end
        ST_EMIT: begin
          if (emit_ren) begin
            oidx      <= oidx + CW'(1);
            out_valid <= 1'b1;
            out_last  <= (oidx == count_m1);
          end else if (out_ready) begin
            out_valid <= 1'b0;
          end
          if (out_valid && out_ready && out_last) begin
            state   <= ST_LOAD;
            count   <= '0;
            dropped <= 1'b0;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

`ifndef SYNTH
  // A RAM is never read and written in the same cycle.
  a_no_rw_a: assert property (@(posedge clk) disable iff (rst)
    !(a_ctl.wen && a_ctl.ren))
    else $error("RAM A read and written in one cycle");
  a_no_rw_b: assert property (@(posedge clk) disable iff (rst)
    !(b_ctl.wen && b_ctl.ren))
    else $error("RAM B read and written in one cycle");
  // Every pass moves each stored key exactly once.
  a_pass_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TAIL) |-> (pos_next == count))
    else $error("pass did not move every key exactly once");
  // The store never holds more than its capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_KEYS))
    else $error("key count above capacity");
  // Keys are only taken while nothing is waiting on the output.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input open while output pending");
`endif

endmodule

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for base4_key_radix_sorter_core: loads key sets over the input
// stream, predicts each sorted run and checks every output transaction against it.
// Depends on b4rs_pkg and the base4_key_radix_sorter_core RTL.

module tb_top;

  import b4rs_pkg::*;

  localparam int KEYS_MAX     = 64;
  localparam int SORT_DIGITS  = 10;
  localparam int ITEM_TARGET  = 410;
  localparam int HOLD_CYCLES  = 1500;
  localparam int DRAIN_CYCLES = 50;
  // Only the low 2*DIGITS key bits take part in the ordering.
  localparam logic [63:0] DIGIT_MASK = (64'd1 << (2 * SORT_DIGITS)) - 64'd1;

  typedef struct packed {
    key_t key;
    logic is_last;
    logic ovf;
  } sorted_item_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;
  logic              s_tlast = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic              m_tlast;
  logic              m_tuser;

  // Predictor state: keys of the set being loaded and the dropped-key flag.
  key_t         set_keys[$];
  logic         set_dropped = 1'b0;
  // Sorted keys still to come out of the block, oldest first.
  sorted_item_t sorted_run_q[$];

  int error_count = 0;
  int items_sent  = 0;
  bit sender_idles = 1'b0;
  bit sink_stalls  = 1'b0;
  bit hold_req     = 1'b0;

  base4_key_radix_sorter_core #(
    .MAX_KEYS(KEYS_MAX),
    .DIGITS  (SORT_DIGITS)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stable insertion sort of the loaded set; queues the expected run and clears the set.
  function automatic void close_set();
    key_t         run[$];
    key_t         held;
    int           j;
    sorted_item_t item;
    run = set_keys;
    for (int i = 1; i < run.size(); i++) begin
      held = run[i];
      j = i;
      while (j > 0 && (64'(run[j-1]) & DIGIT_MASK) > (64'(held) & DIGIT_MASK)) begin
        run[j] = run[j-1];
        j--;
      end
      run[j] = held;
    end
    for (int i = 0; i < run.size(); i++) begin
      item.key     = run[i];
      item.is_last = (i == run.size() - 1);
      item.ovf     = set_dropped;
      sorted_run_q.push_back(item);
    end
    set_keys.delete();
    set_dropped = 1'b0;
  endfunction

  // Input transactions feed the predictor.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      if (set_keys.size() < KEYS_MAX) begin
        set_keys.push_back(s_tdata[KEY_W-1:0]);
      end else begin
        set_dropped = 1'b1;
      end
      if (s_tlast) begin
        close_set();
      end
    end
  end

  // Each output transaction is checked against the oldest expected key.
  always @(posedge clk) begin
    sorted_item_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (sorted_run_q.size() == 0) begin
        $display("%0t: unexpected output key, expected none, actual %h", $time,
                 m_tdata[KEY_W-1:0]);
        error_count++;
      end else begin
        want = sorted_run_q.pop_front();
        if (m_tdata[KEY_W-1:0] !== want.key) begin
          $display("%0t: sorted_key mismatch, expected %h, actual %h", $time, want.key,
                   m_tdata[KEY_W-1:0]);
          error_count++;
        end
        if (m_tlast !== want.is_last) begin
          $display("%0t: end_of_run mismatch, expected %b, actual %b", $time, want.is_last,
                   m_tlast);
          error_count++;
        end
        if (m_tuser !== want.ovf) begin
          $display("%0t: overflow mismatch, expected %b, actual %b", $time, want.ovf,
                   m_tuser);
          error_count++;
        end
      end
    end
  end

  // Sink: random stalls when enabled, and a long hold-off on request.
  always begin
    @(posedge clk);
    if (hold_req) begin
      m_tready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_req = 1'b0;
    end else if (sink_stalls && $urandom_range(0, 99) < 13) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Offers one key and waits until the transaction is taken.
  task automatic send_key(input key_t k, input bit is_last);
    if (sender_idles && $urandom_range(0, 99) < 15) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(DATA_W - KEY_W){1'b0}}, k};
    s_tlast  <= is_last;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Random key: mostly full range, sometimes from a tiny pool so that duplicates occur.
  function automatic key_t random_key();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return key_t'($urandom);
    if (pick < 80) return key_t'($urandom_range(0, 3)) * key_t'(20'h55555);
    return key_t'($urandom_range(0, 15)) << (2 * $urandom_range(0, 8));
  endfunction

  task automatic send_random_set(input int n);
    for (int i = 0; i < n; i++) begin
      send_key(random_key(), i == n - 1);
    end
  endtask

  // Extremes of the key, single-key set, equal keys and keys differing in one digit.
  task automatic test_extremes();
    key_t mixed[$];
    sender_idles = 1'b0;
    sink_stalls  = 1'b0;
    send_key(20'hFFFFF, 1'b1);
    send_key(20'h00000, 1'b1);
    mixed = '{20'hFFFFF, 20'h00000, 20'hAAAAA, 20'h55555, 20'h00001, 20'h80000,
              20'h55555, 20'h3FFFF};
    foreach (mixed[i]) send_key(mixed[i], i == mixed.size() - 1);
    for (int d = 3; d >= 0; d--) send_key(key_t'(d), d == 0);
    repeat (3) send_key(20'h12345, 1'b0);
    send_key(20'h12345, 1'b1);
  endtask

  // Exactly full store, then an overflowing set whose last key is itself dropped.
  task automatic test_capacity();
    sender_idles = 1'b1;
    sink_stalls  = 1'b1;
    send_random_set(KEYS_MAX);
    send_random_set(KEYS_MAX + 3);
  endtask

  // The sink holds off while the sender keeps offering the next set.
  task automatic test_long_hold();
    sender_idles = 1'b0;
    hold_req     = 1'b1;
    send_random_set(8);
    send_random_set(10);
  endtask

  // Random set sizes, mostly small, a few full or overflowing.
  task automatic test_random_sets(input int target, input bit idles);
    int pick;
    sender_idles = idles;
    sink_stalls  = idles;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      send_random_set($urandom_range(1, 8));
      else if (pick < 90) send_random_set($urandom_range(9, 24));
      else if (pick < 97) send_random_set($urandom_range(25, KEYS_MAX));
      else                send_random_set($urandom_range(KEYS_MAX + 1, KEYS_MAX + 6));
    end
  endtask

  // Run timeout.
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_capacity();
    test_long_hold();
    test_random_sets(ITEM_TARGET - 60, 1'b1);
    test_random_sets(ITEM_TARGET, 1'b0);
    s_tvalid <= 1'b0;
    while (sorted_run_q.size() != 0 || set_keys.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
